// File: hw/rtl/ssp_pkg.sv
// Shared constants, payload types and controller command type for the shortest-path block.
`default_nettype none
package ssp_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CFG_W        = 6;
  localparam int ADJ_AW       = 2 * VTX_W;
  localparam int ADJ_DEPTH    = 1 << ADJ_AW;
  localparam int W_W          = 16;
  localparam int D_W          = 32;

  localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(MAX_VERTICES);
  localparam logic signed [D_W-1:0] DIST_MAX  = {1'b0, {(D_W-1){1'b1}}};
  localparam logic signed [D_W-1:0] DIST_MIN  = {1'b1, {(D_W-1){1'b0}}};

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [VTX_W-1:0]        from_vertex;
    logic [VTX_W-1:0]        to_vertex;
    logic signed [W_W-1:0]   edge_weight;
    logic [VTX_W-1:0]        source_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]        vertex;
    logic signed [D_W-1:0]   distance;
    logic                    reachable;
    logic                    negative_cycle;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic               clear_en;
    logic [ADJ_AW-1:0]  clear_addr;
    logic               load_en;
    logic               init_en;
    logic [VTX_W-1:0]   src;
    logic               src_ok;
    logic               row_cap;
    logic               scan_en;
    logic               relax;
    logic               out_rd;
    logic               last;
    logic [VTX_W-1:0]   u;
    logic [VTX_W-1:0]   v;
    logic [VTX_W-1:0]   dist_raddr;
  } ssp_cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/ssp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ssp_ctrl.sv
// Controller state machine: clearing pass, run sequencing and result readout.
`default_nettype none
module ssp_ctrl import ssp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             in_action,
  input  wire logic [VTX_W-1:0] in_source,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output logic                  busy,
  output ssp_cmd_t              cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_INIT   = 8'b0000_0100,
    S_ROWRD  = 8'b0000_1000,
    S_ROWCAP = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_DRAIN  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   nv_r;
  logic [ADJ_AW-1:0]  clr_r, clr_nxt;
  logic [VTX_W-1:0]   u_r, u_nxt;
  logic [VTX_W-1:0]   v_r, v_nxt;
  logic [VTX_W-1:0]   pass_r, pass_nxt;
  logic [VTX_W-1:0]   src_r, src_nxt;
  logic [CFG_W-1:0]   n_eff;
  logic [VTX_W-1:0]   n_m1;
  logic               src_ok;
  logic               accept;

  always_comb begin
    if (nv_r == '0) begin
      n_eff = CFG_W'(1);
    end else if (nv_r > CFG_W'(MAX_VERTICES)) begin
      n_eff = CFG_W'(MAX_VERTICES);
    end else begin
      n_eff = nv_r;
    end
  end

  assign n_m1   = VTX_W'(n_eff - CFG_W'(1));
  assign src_ok = CFG_W'(src_r) < n_eff;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    pass_nxt  = pass_r;
    src_nxt   = src_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + ADJ_AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && in_action == ACT_RUN) begin
          src_nxt   = in_source;
          u_nxt     = '0;
          v_nxt     = '0;
          pass_nxt  = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        v_nxt = v_r + VTX_W'(1);
        if (v_r == VTX_W'(MAX_VERTICES - 1)) begin
          v_nxt     = '0;
          state_nxt = src_ok ? S_ROWRD : S_OUT;
        end
      end
      S_ROWRD: begin
        state_nxt = S_ROWCAP;
      end
      S_ROWCAP: begin
        v_nxt     = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (v_r == n_m1) begin
          state_nxt = S_DRAIN;
        end else begin
          v_nxt = v_r + VTX_W'(1);
        end
      end
      S_DRAIN: begin
        v_nxt = '0;
        if (u_r == n_m1) begin
          u_nxt = '0;
          if (pass_r == n_m1) begin
            state_nxt = S_OUT;
          end else begin
            pass_nxt  = pass_r + VTX_W'(1);
            state_nxt = S_ROWRD;
          end
        end else begin
          u_nxt     = u_r + VTX_W'(1);
          state_nxt = S_ROWRD;
        end
      end
      S_OUT: begin
        if (v_r == n_m1) begin
          state_nxt = S_IDLE;
        end else begin
          v_nxt = v_r + VTX_W'(1);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      nv_r    <= CFG_RESET;
      clr_r   <= '0;
      u_r     <= '0;
      v_r     <= '0;
      pass_r  <= '0;
      src_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      u_r     <= u_nxt;
      v_r     <= v_nxt;
      pass_r  <= pass_nxt;
      src_r   <= src_nxt;
      if (cfg_we) begin
        nv_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.clear_en   = (state_r == S_CLEAR);
    cmd.clear_addr = clr_r;
    cmd.load_en    = accept && in_action == ACT_LOAD;
    cmd.init_en    = (state_r == S_INIT);
    cmd.src        = src_r;
    cmd.src_ok     = src_ok;
    cmd.row_cap    = (state_r == S_ROWCAP);
    cmd.scan_en    = (state_r == S_SCAN);
    cmd.relax      = (pass_r != n_m1);
    cmd.out_rd     = (state_r == S_OUT);
    cmd.last       = (v_r == n_m1);
    cmd.u          = u_r;
    cmd.v          = v_r;
    cmd.dist_raddr = (state_r == S_ROWRD) ? u_r : v_r;
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (v_r <= n_m1 && u_r <= n_m1 && pass_r <= n_m1))
    else $error("scan index beyond active vertex count");

  a_check_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && u_r == n_m1 && pass_r == n_m1) |=> (state_r == S_OUT))
    else $error("check pass did not hand over to readout");

  a_out_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && v_r == n_m1) |=> (state_r == S_IDLE && v_r == n_m1))
    else $error("readout did not end after the final vertex");

endmodule
`default_nettype wire

// File: hw/rtl/ssp_dp.sv
// Datapath: adjacency and distance memories, relaxation unit and result register.
`default_nettype none
module ssp_dp import ssp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ssp_cmd_t cmd,
  input  wire in_item_t in_data,
  output logic          out_strobe,
  output out_item_t     out_data
);

  logic                  adj_we;
  logic [ADJ_AW-1:0]     adj_waddr;
  logic [W_W-1:0]        adj_wdata;
  logic [W_W-1:0]        adj_rdata;
  logic                  dist_we;
  logic [VTX_W-1:0]      dist_waddr;
  logic [D_W:0]          dist_wdata;
  logic [D_W:0]          dist_rdata;
  logic                  load_ok;
  logic                  init_reach;

  logic                  scan_q_r;
  logic                  relax_q_r;
  logic [VTX_W-1:0]      v_q_r;
  logic                  out_q_r;
  logic [VTX_W-1:0]      out_vtx_r;
  logic                  out_last_r;
  logic signed [D_W-1:0] dist_u_r;
  logic                  reach_u_r;
  logic                  neg_r;

  logic signed [W_W-1:0] w;
  logic signed [D_W:0]   sum_w;
  logic signed [D_W-1:0] cand;
  logic signed [D_W-1:0] dist_v;
  logic                  reach_v;
  logic                  improvable;
  logic                  relax_we;

  assign load_ok = (CFG_W'(in_data.from_vertex) < CFG_W'(MAX_VERTICES)) &&
                   (CFG_W'(in_data.to_vertex) < CFG_W'(MAX_VERTICES));

  assign adj_we    = cmd.clear_en || (cmd.load_en && load_ok);
  assign adj_waddr = cmd.clear_en ? cmd.clear_addr
                                  : {in_data.from_vertex, in_data.to_vertex};
  assign adj_wdata = cmd.clear_en ? '0 : in_data.edge_weight;

  ssp_ram #(.WIDTH(W_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr ({cmd.u, cmd.v}),
    .rdata (adj_rdata)
  );

  assign w       = adj_rdata;
  assign dist_v  = dist_rdata[D_W-1:0];
  assign reach_v = dist_rdata[D_W];
  assign sum_w   = {dist_u_r[D_W-1], dist_u_r} + {{(D_W+1-W_W){w[W_W-1]}}, w};

  always_comb begin
    case (sum_w[D_W:D_W-1])
      2'b01:   cand = DIST_MAX;
      2'b10:   cand = DIST_MIN;
      default: cand = sum_w[D_W-1:0];
    endcase
  end

  assign improvable = scan_q_r && (w != '0) && reach_u_r && (!reach_v || cand < dist_v);
  assign relax_we   = improvable && relax_q_r;

  assign init_reach = cmd.src_ok && (cmd.v == cmd.src);
  assign dist_we    = cmd.init_en || relax_we;
  assign dist_waddr = cmd.init_en ? cmd.v : v_q_r;
  assign dist_wdata = cmd.init_en ? {init_reach, init_reach ? {D_W{1'b0}} : DIST_MAX}
                                  : {1'b1, cand};

  ssp_ram #(.WIDTH(D_W + 1), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (cmd.dist_raddr),
    .rdata (dist_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_q_r <= 1'b0;
      out_q_r  <= 1'b0;
      neg_r    <= 1'b0;
    end else begin
      scan_q_r <= cmd.scan_en;
      out_q_r  <= cmd.out_rd;
      if (cmd.init_en) begin
        neg_r <= 1'b0;
      end else if (improvable && !relax_q_r) begin
        neg_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    relax_q_r  <= cmd.relax;
    v_q_r      <= cmd.v;
    out_vtx_r  <= cmd.v;
    out_last_r <= cmd.last;
    if (cmd.row_cap) begin
      dist_u_r  <= dist_v;
      reach_u_r <= reach_v;
    end else if (relax_we && v_q_r == cmd.u) begin
      dist_u_r  <= cand;
      reach_u_r <= 1'b1;
    end
  end

  assign out_strobe              = out_q_r;
  assign out_data.vertex         = out_vtx_r;
  assign out_data.distance       = reach_v ? dist_v : DIST_MAX;
  assign out_data.reachable      = reach_v;
  assign out_data.negative_cycle = neg_r;
  assign out_data.last           = out_last_r;

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.init_en && relax_we))
    else $error("distance store written by init and relaxation together");

  a_strobe_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cmd.out_rd) && !scan_q_r)
    else $error("result beat without a readout request");

endmodule
`default_nettype wire

// File: hw/rtl/single_source_shortest_paths_top.sv
// Top level of the Bellman-Ford single-source shortest-path block.
//
// Input channel: an item is taken when start is high and busy is low. A load
// beat (action 0) writes one adjacency entry and leaves busy low. A run beat
// (action 1) raises busy until the readout of the last vertex is under way.
// Configuration: cfg_we writes num_vertices (n). The user must write it
// only while the block is idle; the block itself does not enforce this.
// Run sequence: the distance memory is set up for all 32 vertices, then n
// passes of n rows each run a row fetch, one edge per cycle through the
// adjacency memory read port and a pipeline drain, and the readout of n
// results follows. With a source at or beyond n the edge passes are
// skipped. Results arrive one per cycle for vertices 0 to n-1, each marked
// by out_strobe for a single cycle, last set on vertex n-1. The receiver
// cannot stall; it must take every beat as it comes. After reset the
// adjacency memory is cleared, one entry per cycle over all 1024 entries,
// with busy high; configuration writes are taken during that time.
`default_nettype none
module single_source_shortest_paths_top import ssp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output logic                  out_strobe,
  output out_item_t             out_data
);

  ssp_cmd_t cmd;

  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_data.action),
    .in_source (in_data.source_vertex),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .cmd       (cmd)
  );

  ssp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
